/* rtl/ssl_pkg.sv */
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and codes for the sorted set list core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

    localparam int KEY_W   = 32;
    localparam int ENTRY_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Broadcast from the core to every cell.
    typedef struct packed {
        logic cmp_en;   // capture compare flags against the held key
        logic ins_en;   // open a gap at the lower slot and write the key
        logic del_en;   // close the matching slot from the right
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ssl_cell.sv */
// ----------------------------------------------------------------------------
// ssl_cell
// One slot of the sorted chain: holds a value, compares it with the key and
// takes the key or a neighbor's value on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_cell
    import ssl_pkg::*;
(
    input  wire logic                    clk,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic                    occupied,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic                    left_lt,
    input  wire logic signed [KEY_W-1:0] left_val,
    input  wire logic signed [KEY_W-1:0] right_val,
    output logic signed [KEY_W-1:0]      val,
    output logic                         lt,
    output logic                         eq
);

    logic signed [KEY_W-1:0] val_reg;
    logic                    lt_reg;
    logic                    eq_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            lt_reg <= occupied && (val_reg < key);
            eq_reg <= occupied && (val_reg == key);
        end
        if (ctrl.ins_en)
        begin
            // lt flags form a thermometer: slots past the lower slot shift right
            if (!left_lt)
                val_reg <= left_val;
            else if (!lt_reg)
                val_reg <= key;
        end
        else if (ctrl.del_en)
        begin
            if (!lt_reg)
                val_reg <= right_val;
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

/* rtl/sorted_set_list_core.sv */
// ----------------------------------------------------------------------------
// sorted_set_list_core
// Sequencing: an accepted item passes through the compare, update and done registers in order.
// Overlap: busy is high for the compare cycle,
//   and a new item may be taken in the cycle that the chain shifts.
// Reset: rst_n clears the count and control; cell values hold no reset and
//   are only read below the count. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_list_core
    import ssl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              operation,
    input  wire logic signed [KEY_W-1:0] key_value,
    output logic                         done,
    output logic                         was_present,
    output logic [1:0]                   status,
    output logic [ENTRY_W-1:0]           entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Item registers, held from accept through the shift cycle.
    logic [1:0]              op_reg;
    logic signed [KEY_W-1:0] key_reg;

    // Two-phase sequencing: compare, then shift/update.
    logic cmp_reg;
    logic upd_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                done_reg;
    logic                was_present_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [ENTRY_W-1:0]  entry_count_reg;

    logic signed [KEY_W-1:0] vals [CAPACITY];
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     eq_vec;

    logic       found;
    logic       full;
    logic       do_ins;
    logic       do_del;
    cell_ctrl_t ctrl;

    assign found = |eq_vec;
    assign full  = (count_reg == CNT_W'(CAPACITY));

    // Decide the action in the update cycle from the registered flags.
    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        status_next = found ? ST_DONE : ST_MISSING;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (found)
                    status_next = ST_DUP;
                else if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_DONE;
                    do_ins      = upd_reg;
                end
            end
            OP_DELETE:
            begin
                do_del = upd_reg && found;
            end
            default:
            begin
                // search, and the unused code behaves as search
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_del)
            count_next = count_reg - 1'b1;
    end

    assign ctrl.cmp_en = cmp_reg;
    assign ctrl.ins_en = do_ins;
    assign ctrl.del_en = do_del;

    // Cell chain: values move right on insert, left on delete.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    left_lt_w;
        logic signed [KEY_W-1:0] left_val_w;
        logic signed [KEY_W-1:0] right_val_w;

        if (i == 0)
        begin : g_head
            assign left_lt_w  = 1'b1;
            assign left_val_w = key_reg;
        end
        else
        begin : g_body
            assign left_lt_w  = lt_vec[i-1];
            assign left_val_w = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_val_w = vals[i];
        end
        else
        begin : g_mid
            assign right_val_w = vals[i+1];
        end

        ssl_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < count_reg),
            .key       (key_reg),
            .left_lt   (left_lt_w),
            .left_val  (left_val_w),
            .right_val (right_val_w),
            .val       (vals[i]),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= operation;
            key_reg <= key_value;
        end
        if (upd_reg)
        begin
            was_present_reg <= found;
            status_reg      <= status_next;
            entry_count_reg <= ENTRY_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg   <= 1'b0;
            upd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            cmp_reg   <= start && !busy;
            upd_reg   <= cmp_reg;
            done_reg  <= upd_reg;
            count_reg <= count_next;
        end
    end

    assign busy        = cmp_reg;
    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

/* rtl/ssl_checker.sv */
// ----------------------------------------------------------------------------
// ssl_checker
// Port-level checks on item sequencing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_checker
    import ssl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       was_present,
    input wire logic [1:0] status
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ##2 done)
        else $error("missing result strobe");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy, 2))
        else $error("result strobe without item");

    a_status_presence: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_DUP) == was_present && status != ST_DONE)
              || (status == ST_DONE)
              || (status == ST_DUP && was_present))
        else $error("status disagrees with was_present");

endmodule

bind sorted_set_list_core ssl_checker u_ssl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .was_present (was_present),
    .status      (status)
);

`default_nettype wire
